// ===== rtl/rpn_pkg.sv =====
package rpn_pkg;

    // Defaults for the top-level parameters.
    localparam int STACK_DEPTH_DEFAULT = 64;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Data widths fixed by the character and result formats.
    localparam int CHAR_W  = 8;
    localparam int WORD_W  = 32;
    localparam int DIGIT_W = 4;

    // Number of quotient bits, one per divider step.
    localparam int DIV_STEPS  = WORD_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    // Character codes that carry meaning.
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_STAR  = 8'h2A;
    localparam char_t CH_SLASH = 8'h2F;
    localparam char_t CH_EQUAL = 8'h3D;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_VALUE,
        ST_UNDER,
        ST_DIVZERO,
        ST_OVER
    } status_t;

    // Operations after classification.
    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_EQ
    } op_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_DIVW
    } back_state_t;

    // One classified operation held in the queue.
    typedef struct packed {
        op_t    op;
        digit_t digit;
    } q_entry_t;

    // Queue write side, driven by the front end.
    typedef struct packed {
        logic     push;
        q_entry_t entry;
    } q_wr_t;

    // Queue read side, seen by the back end.
    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_rd_t;

    // Divider request and response.
    typedef struct packed {
        logic  start;
        word_t num;
        word_t den;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quotient;
    } div_rsp_t;

endpackage

// ===== rtl/rpn_char_if.sv =====
interface rpn_char_if;
    import rpn_pkg::*;

    logic  valid;
    logic  ready;
    char_t char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/rpn_result_if.sv =====
interface rpn_result_if;
    import rpn_pkg::*;

    logic               valid;
    logic               ready;
    status_t            status;
    logic signed [31:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink (input valid, input status, input value, output ready);
endinterface

// ===== rtl/rpn_front.sv =====
module rpn_front (
    rpn_char_if.sink      chars,
    input  logic          q_full,
    output rpn_pkg::q_wr_t q_wr
);
    import rpn_pkg::*;

    logic known;
    op_t  op;

    // A beat is taken whenever the queue has room; ignored characters are dropped here.
    assign chars.ready = !q_full;

    // Classify the character into an operation.
    always_comb
    begin
        known = 1'b1;
        op    = OP_DIGIT;
        priority if (chars.char_code >= CH_ZERO && chars.char_code <= CH_NINE)
        begin
            op = OP_DIGIT;
        end
        else if (chars.char_code == CH_PLUS)
        begin
            op = OP_ADD;
        end
        else if (chars.char_code == CH_MINUS)
        begin
            op = OP_SUB;
        end
        else if (chars.char_code == CH_STAR)
        begin
            op = OP_MUL;
        end
        else if (chars.char_code == CH_SLASH)
        begin
            op = OP_DIV;
        end
        else if (chars.char_code == CH_EQUAL)
        begin
            op = OP_EQ;
        end
        else
        begin
            known = 1'b0;
        end
    end

    // Only meaningful characters enter the queue.
    always_comb
    begin
        q_wr.push        = chars.valid && chars.ready && known;
        q_wr.entry.op    = op;
        q_wr.entry.digit = DIGIT_W'(chars.char_code - CH_ZERO);
    end
endmodule

// ===== rtl/rpn_queue.sv =====
module rpn_queue #(
    parameter int QUEUE_DEPTH = rpn_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rpn_pkg::q_wr_t wr,
    input  logic           pop,
    output logic           full,
    output rpn_pkg::q_rd_t rd
);
    import rpn_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    q_entry_t        slots_reg [QUEUE_DEPTH];
    logic [PW-1:0]   head_reg;
    logic [PW-1:0]   head_next;
    logic [PW-1:0]   tail_reg;
    logic [PW-1:0]   tail_next;
    logic [NW-1:0]   fill_reg;
    logic [NW-1:0]   fill_next;

    assign full         = (fill_reg == NW'(QUEUE_DEPTH));
    assign rd.valid     = (fill_reg != '0);
    assign rd.entry     = slots_reg[head_reg];

    // Pointer and fill updates; pointers wrap at the depth.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (wr.push)
        begin
            tail_next = (tail_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PW'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PW'(1);
        end
        if (wr.push && !pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (pop && !wr.push)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            slots_reg[tail_reg] <= wr.entry;
        end
    end
endmodule

// ===== rtl/rpn_divider.sv =====
module rpn_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::div_req_t req,
    output rpn_pkg::div_rsp_t rsp
);
    import rpn_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DIV_STEP_W-1:0] step_next;
    word_t                 rem_reg;
    word_t                 rem_next;
    word_t                 quo_reg;
    word_t                 quo_next;
    word_t                 den_reg;
    word_t                 den_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [WORD_W:0]       shifted;
    logic [WORD_W:0]       trial;

    // Restoring division on magnitudes, one quotient bit per cycle.
    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.num[WORD_W-1] ? (WORD_W'(0) - req.num) : req.num;
            den_next  = req.den[WORD_W-1] ? (WORD_W'(0) - req.den) : req.den;
            neg_next  = req.num[WORD_W-1] ^ req.den[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (trial[WORD_W])
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            step_next = step_reg + DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // The sign is applied on the way out; the quotient holds after done.
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (WORD_W'(0) - quo_reg) : quo_reg;
endmodule

// ===== rtl/rpn_back.sv =====
module rpn_back #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::q_rd_t    q_rd,
    output logic              q_pop,
    output rpn_pkg::div_req_t div_req,
    input  rpn_pkg::div_rsp_t div_rsp,
    rpn_result_if.source      results
);
    import rpn_pkg::*;

    localparam int AW        = $clog2(STACK_DEPTH);
    localparam int CW        = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = 1 << AW;

    // The top entry lives in top_reg; the entries below it live in the memory.
    word_t         stack_mem [MEM_DEPTH];
    word_t         rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    word_t         wr_data;

    back_state_t   state_reg;
    back_state_t   state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    word_t         top_reg;
    word_t         top_next;
    op_t           op_reg;
    op_t           op_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    status_t       out_status_reg;
    status_t       out_status_next;
    word_t         out_value_reg;
    word_t         out_value_next;

    logic          slot_free;
    logic          is_full;
    logic          no_entries;
    logic          below_two;
    logic          div_zero;
    logic          binop;
    logic          emits;
    logic          go;

    // Classification of the head operation against the stack state.
    assign slot_free  = !out_valid_reg || results.ready;
    assign is_full    = (count_reg == CW'(STACK_DEPTH));
    assign no_entries = (count_reg == '0);
    assign below_two  = (count_reg < CW'(2));
    assign div_zero   = (q_rd.entry.op == OP_DIV) && (top_reg == '0);
    assign binop      = (q_rd.entry.op == OP_ADD) || (q_rd.entry.op == OP_SUB) ||
                        (q_rd.entry.op == OP_MUL) || (q_rd.entry.op == OP_DIV);
    assign emits      = ((q_rd.entry.op == OP_DIGIT) && is_full) ||
                        (q_rd.entry.op == OP_EQ) ||
                        (binop && (below_two || div_zero));
    assign go         = (state_reg == BK_IDLE) && q_rd.valid && (!emits || slot_free);
    assign q_pop      = go;
    assign rd_addr    = AW'(count_reg - CW'(2));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (go && binop && !below_two && !div_zero)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = (op_reg == OP_DIV) ? BK_DIVW : BK_IDLE;
            end
            BK_DIVW:
            begin
                if (div_rsp.done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and result control.
    always_comb
    begin
        count_next      = count_reg;
        top_next        = top_reg;
        op_next         = op_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        wr_en           = 1'b0;
        wr_addr         = AW'(count_reg - CW'(1));
        wr_data         = top_reg;
        div_req.start   = 1'b0;
        div_req.num     = rd_data_reg;
        div_req.den     = top_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (go)
                begin
                    unique case (q_rd.entry.op)
                        OP_DIGIT:
                        begin
                            if (is_full)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_OVER;
                                out_value_next  = '0;
                                count_next      = '0;
                            end
                            else
                            begin
                                wr_en      = !no_entries;
                                top_next   = WORD_W'(q_rd.entry.digit);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_EQ:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = no_entries ? ST_UNDER : ST_VALUE;
                            out_value_next  = no_entries ? '0 : top_reg;
                            count_next      = '0;
                        end
                        default:
                        begin
                            if (below_two)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_UNDER;
                                out_value_next  = '0;
                                count_next      = '0;
                            end
                            else if (div_zero)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_DIVZERO;
                                out_value_next  = '0;
                                count_next      = '0;
                            end
                            else
                            begin
                                op_next = q_rd.entry.op;
                            end
                        end
                    endcase
                end
            end
            BK_EXEC:
            begin
                unique case (op_reg)
                    OP_ADD:
                    begin
                        top_next   = rd_data_reg + top_reg;
                        count_next = count_reg - CW'(1);
                    end
                    OP_SUB:
                    begin
                        top_next   = rd_data_reg - top_reg;
                        count_next = count_reg - CW'(1);
                    end
                    OP_MUL:
                    begin
                        top_next   = rd_data_reg * top_reg;
                        count_next = count_reg - CW'(1);
                    end
                    OP_DIV:
                    begin
                        div_req.start = 1'b1;
                    end
                    default:
                    begin
                        top_next = top_reg;
                    end
                endcase
            end
            BK_DIVW:
            begin
                if (div_rsp.done)
                begin
                    top_next   = div_rsp.quotient;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                top_next = top_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        op_reg         <= op_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    assign results.valid  = out_valid_reg;
    assign results.status = out_status_reg;
    assign results.value  = out_value_reg;
endmodule

// ===== rtl/rpn_stack_calculator_unit.sv =====
// Channel   Role    Payload                      Beat
// chars     sink    char_code[7:0]               one character
// results   source  status[1:0], value[31:0]     one value or status
//
// A digit is done in the back end as it is popped; + - * take a stack memory
// read, then compute; / takes decode, operand read, 32 quotient steps of the
// iterative divider, then writeback. Ignored characters are dropped at
// the front. Reset clears the stack count, the queue and the result register;
// no clearing pass is needed. A stalled result blocks only operations that
// emit; the queue keeps taking characters while it has room.
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEFAULT,
    parameter int QUEUE_DEPTH = rpn_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    rpn_char_if.sink     chars,
    rpn_result_if.source results
);
    import rpn_pkg::*;

    q_wr_t    q_wr;
    q_rd_t    q_rd;
    logic     q_full;
    logic     q_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Front end: classification into the queue.
    rpn_front u_front (
        .chars  (chars),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    // Decoupling queue.
    rpn_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .pop   (q_pop),
        .full  (q_full),
        .rd    (q_rd)
    );

    // Divider used by the back end.
    rpn_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Back end: stack engine and result register.
    rpn_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_rd    (q_rd),
        .q_pop   (q_pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .results (results)
    );

`ifndef SYNTHESIS
    // The front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_wr.push |-> !q_full)
        else $error("push into full queue");

    // The back end never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_rd.valid)
        else $error("pop from empty queue");

    // A divide cannot finish in the cycle after it starts.
    assert property (@(posedge clk) disable iff (!rst_n) div_req.start |=> !div_rsp.done)
        else $error("divider finished too early");

    // Error statuses carry a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status != ST_VALUE) |-> (results.value == 0))
        else $error("nonzero value with error status");
`endif
endmodule

// ===== tb/testbench.sv =====
module testbench;
    import rpn_pkg::*;

    localparam int CALC_DEPTH = STACK_DEPTH_DEFAULT;

    // One result beat as the calculator should produce it.
    typedef struct {
        status_t            status;
        logic signed [31:0] value;
    } calc_result_t;

    logic clk;
    logic rst_n;

    rpn_char_if   chars_if ();
    rpn_result_if results_if ();

    rpn_stack_calculator_unit #(
        .STACK_DEPTH(CALC_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .chars(chars_if),
        .results(results_if)
    );

    // Shadow copy of the operand stack and the results still owed by the block.
    word_t        model_stack [CALC_DEPTH];
    int unsigned  model_depth;
    calc_result_t pending_results [$];

    int mismatch_count;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;

    // Free-running clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs or loses a beat.
    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic bit is_digit(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic bit is_operator(input char_t c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

    function automatic bit is_meaningful(input char_t c);
        return is_digit(c) || is_operator(c) || (c == CH_EQUAL);
    endfunction

    // Queues one result and clears the stack, as every emitting case does.
    function automatic void owe_result(input status_t st, input word_t v);
        calc_result_t r;
        r.status = st;
        r.value  = v;
        pending_results.push_back(r);
        model_depth = 0;
    endfunction

    // Signed division truncating toward zero, with the most negative value over
    // minus one wrapping back to itself.
    function automatic word_t signed_quotient(input word_t num, input word_t den);
        word_t mag_n;
        word_t mag_d;
        word_t q;
        mag_n = num[WORD_W-1] ? -num : num;
        mag_d = den[WORD_W-1] ? -den : den;
        q = mag_n / mag_d;
        return (num[WORD_W-1] ^ den[WORD_W-1]) ? -q : q;
    endfunction

    // Applies one accepted character to the shadow stack.
    function automatic void predict_char(input char_t c);
        word_t lhs;
        word_t rhs;
        word_t res;
        if (is_digit(c))
        begin
            if (model_depth >= CALC_DEPTH)
                owe_result(ST_OVER, '0);
            else
            begin
                model_stack[model_depth] = word_t'(c - CH_ZERO);
                model_depth++;
            end
        end
        else if (c == CH_EQUAL)
        begin
            if (model_depth < 1)
                owe_result(ST_UNDER, '0);
            else
                owe_result(ST_VALUE, model_stack[model_depth-1]);
        end
        else if (is_operator(c))
        begin
            if (model_depth < 2)
                owe_result(ST_UNDER, '0);
            else
            begin
                rhs = model_stack[model_depth-1];
                lhs = model_stack[model_depth-2];
                if (c == CH_SLASH && rhs == '0)
                    owe_result(ST_DIVZERO, '0);
                else
                begin
                    case (c)
                        CH_PLUS:  res = lhs + rhs;
                        CH_MINUS: res = lhs - rhs;
                        CH_STAR:  res = lhs * rhs;
                        default:  res = signed_quotient(lhs, rhs);
                    endcase
                    model_depth--;
                    model_stack[model_depth-1] = res;
                end
            end
        end
    endfunction

    function automatic char_t random_digit();
        return char_t'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic char_t random_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic char_t random_symbol();
        if ($urandom_range(0, 4) == 0)
            return CH_EQUAL;
        return random_operator();
    endfunction

    function automatic char_t random_ignored();
        char_t c;
        do
            c = char_t'($urandom_range(0, 255));
        while (is_meaningful(c));
        return c;
    endfunction

    // Sends one character beat, with random idle cycles ahead of it, and
    // updates the prediction at the edge where it is taken.
    task automatic send_char(input char_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= c;
        // Ready comes from registered state only, so its value at the falling
        // edge is the one that the next rising edge sees.
        @(negedge clk);
        while (!chars_if.ready)
            @(negedge clk);
        @(posedge clk);
        predict_char(c);
        if (is_meaningful(c))
            items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(char_t'(s[i]));
    endtask

    // Leaves the most negative word on top: -2 times eight to the tenth.
    task automatic push_most_negative();
        send_text("02-");
        repeat (10)
            send_text("8*");
    endtask

    // Receiver side: ready drops at random according to the stall rate.
    initial
    begin
        results_if.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        results_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compares every result beat with the oldest owed result.
    always @(posedge clk)
    begin : check_results
        calc_result_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result beat status %0d value %0d with none owed",
                                          results_if.status, results_if.value));
            else
            begin
                want = pending_results.pop_front();
                if (results_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              results_if.status, want.status));
                if (results_if.value !== want.value)
                    report_mismatch($sformatf("value %0d, wanted %0d",
                                              results_if.value, want.value));
            end
        end
    end

    // Each operator, plus truncation of a negative quotient.
    task automatic test_arithmetic();
        send_text("99+=");
        send_text("37-=");
        send_text("98*=");
        send_text("92/=");
        send_text("07-2/=");
        send_text("12=");
    endtask

    // Operators and equals on a stack that holds too little.
    task automatic test_too_few_operands();
        send_text("=");
        send_text("+");
        send_text("5-");
        send_text("*");
        send_text("/");
        send_text("4=");
    endtask

    // A zero divisor must clear the stack, so the following equals underflows.
    task automatic test_divide_by_zero();
        send_text("70/");
        send_text("=");
        send_text("00/");
    endtask

    // Bytes around the meaningful codes and at both ends of the range.
    task automatic test_ignored_chars();
        send_char(8'h00);
        send_char(8'hFF);
        send_char(char_t'(" "));
        send_char(char_t'("q"));
        send_char(CH_STAR - 8'd1);
        send_char(CH_PLUS + 8'd1);
        send_char(CH_MINUS + 8'd1);
        send_char(CH_ZERO - 8'd1);
        send_char(CH_NINE + 8'd1);
        send_char(CH_EQUAL - 8'd1);
        send_char(CH_EQUAL + 8'd1);
        send_char(8'h80);
        send_text("6");
        send_char(8'h5A);
        send_text("=");
    endtask

    // The most negative word divided by minus one, and the largest word.
    task automatic test_word_extremes();
        push_most_negative();
        send_text("01-/=");
        push_most_negative();
        send_text("1-=");
        push_most_negative();
        send_text("1-1+=");
    endtask

    // Fills the stack, then one more digit overflows and clears it.
    task automatic test_full_stack();
        repeat (CALC_DEPTH)
            send_char(random_digit());
        send_char(random_digit());
        send_text("=");
        repeat (CALC_DEPTH)
            send_char(random_digit());
        send_text("=");
    endtask

    // One random sequence: mostly well-formed expressions, with noise, short
    // broken sequences and the odd stack overflow mixed in.
    task automatic send_random_sequence();
        int kind;
        int ops_left;
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            repeat ($urandom_range(1, 4))
                send_char(char_t'($urandom_range(0, 255)));
        end
        else if (kind < 7)
        begin
            while (model_depth < CALC_DEPTH)
                send_char(random_digit());
            if ($urandom_range(0, 1) == 0)
                send_char(random_digit());
            else
                send_char(CH_EQUAL);
        end
        else if (kind < 12)
        begin
            repeat ($urandom_range(0, 1))
                send_char(random_digit());
            send_char(random_symbol());
        end
        else
        begin
            ops_left = $urandom_range(1, 12);
            while (ops_left > 0)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_char(random_ignored());
                else if (model_depth < 2 || (model_depth < 8 && $urandom_range(0, 1) == 0))
                    send_char(random_digit());
                else
                begin
                    send_char(random_operator());
                    ops_left--;
                end
            end
            if ($urandom_range(0, 9) != 0)
                send_char(CH_EQUAL);
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            send_random_sequence();
    endtask

    initial
    begin
        mismatch_count = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        model_depth    = 0;
        chars_if.valid     = 1'b0;
        chars_if.char_code = '0;
        rst_n = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        test_arithmetic();
        test_too_few_operands();
        test_divide_by_zero();
        test_ignored_chars();
        test_word_extremes();
        test_full_stack();

        test_random_traffic(0, 0, 180);
        test_random_traffic(70, 0, 180);
        test_random_traffic(0, 70, 180);
        test_random_traffic(33, 33, 180);

        chars_if.valid <= 1'b0;

        // Drain the owed results, then give the divider time to finish.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/rpn_pkg.sv
rtl/rpn_char_if.sv
rtl/rpn_result_if.sv
rtl/rpn_front.sv
rtl/rpn_queue.sv
rtl/rpn_divider.sv
rtl/rpn_back.sv
rtl/rpn_stack_calculator_unit.sv
tb/testbench.sv
